>>> rtl/grsd_pkg.sv
// Package for the signed Golomb-Rice decoder.
// Holds the item classes, status codes, field widths and the queue item type.
// No dependencies.
package grsd_pkg;

    localparam int K_W          = 5;
    localparam int RICE_K_W     = 8;
    localparam int RAW_W        = 8;
    localparam int ZERO_RUN_W   = 4;
    localparam int GATHER_W     = 35;
    localparam int FOLD_W       = GATHER_W + 1;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int ERR_BYTE_W   = 45;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [RAW_W-1:0]    RAW_WIDTH_RESET = 8'd8;
    localparam logic [RAW_W-1:0]    RAW_WIDTH_MAX   = 8'd31;
    localparam logic [RICE_K_W-1:0] K_LIMIT         = 8'd32;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SYNTAX  = 2'd2;

    localparam logic [1:0] CLS_START_OK  = 2'd0;
    localparam logic [1:0] CLS_START_BAD = 2'd1;
    localparam logic [1:0] CLS_BIT_ZERO  = 2'd2;
    localparam logic [1:0] CLS_BIT_ONE   = 2'd3;

    typedef struct packed {
        logic [1:0]            cls;
        logic [K_W-1:0]        k;
        logic [ERR_BYTE_W-1:0] start_byte;
    } t_item;

endpackage

>>> rtl/grsd_front.sv
// Front end of the decoder: takes requests, counts stream bits and classifies
// each request for the back end. Depends on grsd_pkg.
module grsd_front #(
    parameter int POSITION_BITS = 48
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_kind,
    input  logic [grsd_pkg::RICE_K_W-1:0] i_rice_k,
    input  logic                      i_stream_bit,
    input  logic [grsd_pkg::RAW_W-1:0] i_raw_width,
    output logic                      o_push_valid,
    input  logic                      i_push_ready,
    output grsd_pkg::t_item           o_push_item
);
    import grsd_pkg::*;

    logic [POSITION_BITS-1:0]            r_bit_count;
    logic [POSITION_BITS-1:0]            n_bit_count;
    logic [POSITION_BITS+ERR_BYTE_W-1:0] pos_wide;
    logic                                raw_bad;
    logic                                accept;

    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;
    assign accept       = i_in_valid && i_push_ready;

    assign raw_bad  = (i_raw_width == '0) || (i_raw_width > RAW_WIDTH_MAX);
    assign pos_wide = {{ERR_BYTE_W{1'b0}}, r_bit_count} >> 3;

    always_comb begin
        o_push_item.k          = i_rice_k[K_W-1:0];
        o_push_item.start_byte = pos_wide[ERR_BYTE_W-1:0];
        if (i_kind) begin
            o_push_item.cls = i_stream_bit ? CLS_BIT_ONE : CLS_BIT_ZERO;
        end else if (raw_bad || (i_rice_k >= K_LIMIT)) begin
            o_push_item.cls = CLS_START_BAD;
        end else begin
            o_push_item.cls = CLS_START_OK;
        end
    end

    always_comb begin
        n_bit_count = r_bit_count;
        if (accept && i_kind) begin
            n_bit_count = r_bit_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= '0;
        end else begin
            r_bit_count <= n_bit_count;
        end
    end

endmodule

>>> rtl/grsd_queue.sv
// Short request queue between the front and back ends of the decoder.
// Depends on grsd_pkg for the item type and depth.
module grsd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  grsd_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output grsd_pkg::t_item o_pop_item
);
    import grsd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

    t_item            r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

>>> rtl/grsd_back.sv
// Back end of the decoder: prefix, suffix and escape sequencer with the
// registered result stage. Depends on grsd_pkg.
module grsd_back #(
    parameter int PREFIX_LIMIT = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pop_valid,
    output logic                          o_pop_ready,
    input  grsd_pkg::t_item               i_pop_item,
    input  logic [grsd_pkg::RAW_W-1:0]    i_raw_width,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [grsd_pkg::VALUE_W-1:0] o_value,
    output logic [grsd_pkg::STATUS_W-1:0] o_status,
    output logic [grsd_pkg::ERR_BYTE_W-1:0] o_error_byte
);
    import grsd_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_PREFIX = 2'd1;
    localparam logic [1:0] PH_SUFFIX = 2'd2;
    localparam logic [1:0] PH_ESCAPE = 2'd3;

    localparam logic [ZERO_RUN_W-1:0] RUN_LIMIT  = ZERO_RUN_W'(PREFIX_LIMIT);
    localparam logic [GATHER_W-1:0]   LIMIT_BASE = GATHER_W'(PREFIX_LIMIT);
    localparam logic [FOLD_W-1:0]     ESC_OFFSET = FOLD_W'(PREFIX_LIMIT - 1);

    logic [1:0]            r_phase,     n_phase;
    logic [ZERO_RUN_W-1:0] r_zero_run,  n_zero_run;
    logic [K_W-1:0]        r_held_k,    n_held_k;
    logic [K_W-1:0]        r_bits_left, n_bits_left;
    logic [GATHER_W-1:0]   r_gathered,  n_gathered;
    logic [GATHER_W-1:0]   r_limit,     n_limit;
    logic [ERR_BYTE_W-1:0] r_start_byte, n_start_byte;
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_value,     n_value;
    logic [STATUS_W-1:0]   r_status,    n_status;
    logic [ERR_BYTE_W-1:0] r_error_byte, n_error_byte;

    logic                  step;
    logic                  do_emit;
    logic                  do_finish;
    logic                  fin_escaped;
    logic [GATHER_W-1:0]   fin_gathered;
    logic [FOLD_W-1:0]     fin_folded;
    logic [ZERO_RUN_W-1:0] run_inc;
    logic [GATHER_W-1:0]   shifted;
    logic [K_W-1:0]        left_dec;
    logic                  raw_bad;
    logic                  stream_bit;
    logic [VALUE_W-1:0]    mag;

    assign o_pop_ready = !r_out_valid || i_out_ready;
    assign step        = i_pop_valid && o_pop_ready;
    assign raw_bad     = (i_raw_width == '0) || (i_raw_width > RAW_WIDTH_MAX);
    assign stream_bit  = (i_pop_item.cls == CLS_BIT_ONE);
    assign run_inc     = r_zero_run + 1'b1;
    assign shifted     = {r_gathered[GATHER_W-2:0], stream_bit};
    assign left_dec    = r_bits_left - 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_zero_run   = r_zero_run;
        n_held_k     = r_held_k;
        n_bits_left  = r_bits_left;
        n_gathered   = r_gathered;
        n_limit      = r_limit;
        n_start_byte = r_start_byte;
        do_emit      = 1'b0;
        do_finish    = 1'b0;
        fin_escaped  = 1'b0;
        fin_gathered = shifted;
        n_status     = ST_INVALID;
        n_error_byte = r_start_byte;
        if (step) begin
            case (i_pop_item.cls)
                CLS_START_BAD: begin
                    n_start_byte = i_pop_item.start_byte;
                    n_error_byte = i_pop_item.start_byte;
                    do_emit      = 1'b1;
                    n_phase      = PH_IDLE;
                end
                CLS_START_OK: begin
                    n_start_byte = i_pop_item.start_byte;
                    n_held_k     = i_pop_item.k;
                    n_limit      = LIMIT_BASE << i_pop_item.k;
                    n_zero_run   = '0;
                    n_bits_left  = '0;
                    n_gathered   = '0;
                    n_phase      = PH_PREFIX;
                end
                default: begin
                    case (r_phase)
                        PH_PREFIX: begin
                            if (stream_bit) begin
                                n_gathered = GATHER_W'(r_zero_run);
                                if (r_held_k == '0) begin
                                    fin_gathered = GATHER_W'(r_zero_run);
                                    do_finish    = 1'b1;
                                end else begin
                                    n_bits_left = r_held_k;
                                    n_phase     = PH_SUFFIX;
                                end
                            end else begin
                                n_zero_run = run_inc;
                                if (run_inc >= RUN_LIMIT) begin
                                    if (raw_bad) begin
                                        do_emit = 1'b1;
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_bits_left = i_raw_width[K_W-1:0];
                                        n_gathered  = '0;
                                        n_phase     = PH_ESCAPE;
                                    end
                                end
                            end
                        end
                        PH_SUFFIX, PH_ESCAPE: begin
                            n_gathered  = shifted;
                            n_bits_left = left_dec;
                            if (left_dec == '0) begin
                                do_finish   = 1'b1;
                                fin_escaped = (r_phase == PH_ESCAPE);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            endcase
        end

        fin_folded = {1'b0, fin_gathered} + (fin_escaped ? ESC_OFFSET : '0);
        mag        = fin_folded[VALUE_W:1];
        n_value    = '0;
        if (do_finish) begin
            do_emit = 1'b1;
            n_phase = PH_IDLE;
            if ((fin_escaped && (fin_folded < {1'b0, r_limit}))
                    || (fin_folded[FOLD_W-1:VALUE_W] != '0)) begin
                n_status = ST_SYNTAX;
            end else begin
                n_status = ST_OK;
                n_value  = fin_folded[0] ? ~mag : mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_zero_run  <= '0;
            r_held_k    <= '0;
            r_bits_left <= '0;
            r_gathered  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_zero_run  <= n_zero_run;
            r_held_k    <= n_held_k;
            r_bits_left <= n_bits_left;
            r_gathered  <= n_gathered;
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit      <= n_limit;
        r_start_byte <= n_start_byte;
        if (do_emit) begin
            r_value      <= n_value;
            r_status     <= n_status;
            r_error_byte <= n_error_byte;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_status     = r_status;
    assign o_error_byte = r_error_byte;

endmodule

>>> rtl/golomb_rice_signed_decoder.sv
// Signed Golomb-Rice decoder with escape codes, one stream bit per request.
// Throughput is one request per cycle, set by the back-end sequencer taking one
// queued request each cycle while its result register is free or being drained.
// A result is registered in the back end after the request that completes it passes through the queue.
// Synchronous active-low reset empties the queue, clears the bit position and
// the decoder state, and sets the raw width register to 8; no clearing pass.
module golomb_rice_signed_decoder #(
    parameter int PREFIX_LIMIT  = 12,
    parameter int POSITION_BITS = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [grsd_pkg::RAW_W-1:0]      i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_kind,
    input  logic [grsd_pkg::RICE_K_W-1:0]   i_rice_k,
    input  logic                            i_stream_bit,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [grsd_pkg::VALUE_W-1:0] o_value,
    output logic [grsd_pkg::STATUS_W-1:0]   o_status,
    output logic [grsd_pkg::ERR_BYTE_W-1:0] o_error_byte
);
    import grsd_pkg::*;

    logic [RAW_W-1:0] r_raw_width;
    logic             push_valid;
    logic             push_ready;
    t_item            push_item;
    logic             pop_valid;
    logic             pop_ready;
    t_item            pop_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_width <= RAW_WIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_raw_width <= i_cfg_wr_data;
        end
    end

    grsd_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_rice_k     (i_rice_k),
        .i_stream_bit (i_stream_bit),
        .i_raw_width  (r_raw_width),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    grsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    grsd_back #(
        .PREFIX_LIMIT(PREFIX_LIMIT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_item   (pop_item),
        .i_raw_width  (r_raw_width),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_value      (o_value),
        .o_status     (o_status),
        .o_error_byte (o_error_byte)
    );

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_value == '0))
        else $error("Error result carries a nonzero value.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("Reset did not empty the result stage and queue.");

    a_stall_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !pop_ready)
        else $error("Back end advanced while a result was stalled.");

endmodule

>>> dv/grsd_symbol_checker.sv
`timescale 1ns / 100ps
// Request codes shared by the testbench and the symbol checker, and the checker itself.
// The checker mirrors the decoder state, predicts each symbol result and compares it.
// Depends on grsd_pkg for field widths, limits and status codes.
package grsd_tb_pkg;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BIT   = 1'b1;

endpackage

module grsd_symbol_checker #(
    parameter int PREFIX_LIMIT  = 12,
    parameter int POSITION_BITS = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [grsd_pkg::RAW_W-1:0]          i_cfg_wr_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_kind,
    input  logic [grsd_pkg::RICE_K_W-1:0]       i_rice_k,
    input  logic                                i_stream_bit,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [grsd_pkg::VALUE_W-1:0] i_value,
    input  logic [grsd_pkg::STATUS_W-1:0]       i_status,
    input  logic [grsd_pkg::ERR_BYTE_W-1:0]     i_error_byte,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import grsd_pkg::*;
    import grsd_tb_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PREFIX,
        PH_SUFFIX,
        PH_ESCAPE
    } decode_phase_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
        logic [ERR_BYTE_W-1:0]     error_byte;
    } symbol_result_t;

    decode_phase_t            phase;
    logic [ZERO_RUN_W-1:0]    zero_run;
    logic [K_W-1:0]           held_k;
    logic [5:0]               bits_left;
    logic [GATHER_W-1:0]      gathered;
    logic [POSITION_BITS-1:0] bit_count;
    logic [POSITION_BITS-1:0] symbol_start;
    logic [RAW_W-1:0]         raw_width;
    symbol_result_t           expected_symbols[$];
    symbol_result_t           oldest;
    int                       fail_total = 0;

    function automatic logic width_valid();
        return raw_width != '0 && raw_width <= RAW_WIDTH_MAX;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_total++;
    endtask

    task automatic push_result(input logic [STATUS_W-1:0] status,
                               input logic [VALUE_W-1:0] value);
        symbol_result_t r;
        logic [63:0]    start_wide;
        start_wide   = 64'(symbol_start) >> 3;
        r.value      = (status == ST_OK) ? value : '0;
        r.status     = status;
        r.error_byte = start_wide[ERR_BYTE_W-1:0];
        expected_symbols.push_back(r);
        phase = PH_IDLE;
    endtask

    task automatic finish_symbol(input logic [63:0] folded, input logic escaped);
        logic [63:0] mag;
        logic [63:0] max_regular;
        max_regular = (64'(PREFIX_LIMIT) << held_k) - 64'd1;
        if (escaped && folded <= max_regular) begin
            push_result(ST_SYNTAX, '0);
        end else if (folded >= 64'h1_0000_0000) begin
            push_result(ST_SYNTAX, '0);
        end else begin
            mag = folded >> 1;
            push_result(ST_OK, folded[0] ? ~mag[VALUE_W-1:0] : mag[VALUE_W-1:0]);
        end
    endtask

    task automatic decode_request(input logic kind, input logic [RICE_K_W-1:0] k,
                                  input logic b);
        if (kind == KIND_START) begin
            symbol_start = bit_count;
            if (k >= K_LIMIT || !width_valid()) begin
                push_result(ST_INVALID, '0);
            end else begin
                held_k    = k[K_W-1:0];
                zero_run  = '0;
                bits_left = '0;
                gathered  = '0;
                phase     = PH_PREFIX;
            end
        end else begin
            bit_count = bit_count + 1'b1;
            case (phase)
                PH_PREFIX: begin
                    if (b) begin
                        gathered = GATHER_W'(zero_run);
                        if (held_k == '0) begin
                            finish_symbol(64'(gathered), 1'b0);
                        end else begin
                            bits_left = 6'(held_k);
                            phase     = PH_SUFFIX;
                        end
                    end else begin
                        zero_run = zero_run + 1'b1;
                        if (zero_run >= PREFIX_LIMIT) begin
                            if (!width_valid()) begin
                                push_result(ST_INVALID, '0);
                            end else begin
                                bits_left = raw_width[5:0];
                                gathered  = '0;
                                phase     = PH_ESCAPE;
                            end
                        end
                    end
                end
                PH_SUFFIX, PH_ESCAPE: begin
                    gathered  = {gathered[GATHER_W-2:0], b};
                    bits_left = bits_left - 6'd1;
                    if (bits_left == '0) begin
                        if (phase == PH_SUFFIX) begin
                            finish_symbol(64'(gathered), 1'b0);
                        end else begin
                            finish_symbol(64'(gathered) + 64'(PREFIX_LIMIT - 1), 1'b1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase        = PH_IDLE;
            zero_run     = '0;
            held_k       = '0;
            bits_left    = '0;
            gathered     = '0;
            bit_count    = '0;
            symbol_start = '0;
            raw_width    = RAW_WIDTH_RESET;
            expected_symbols.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_symbols.size() == 0) begin
                    report_mismatch("result with no request pending", 64'(i_status), '0);
                end else begin
                    oldest = expected_symbols.pop_front();
                    if (i_value !== oldest.value) begin
                        report_mismatch("value", 64'(i_value), 64'(oldest.value));
                    end
                    if (i_status !== oldest.status) begin
                        report_mismatch("status", 64'(i_status), 64'(oldest.status));
                    end
                    if (i_error_byte !== oldest.error_byte) begin
                        report_mismatch("error_byte", 64'(i_error_byte),
                                        64'(oldest.error_byte));
                    end
                end
            end
            if (i_cfg_wr_en) begin
                raw_width = i_cfg_wr_data;
            end
            if (i_in_valid && i_in_ready) begin
                decode_request(i_kind, i_rice_k, i_stream_bit);
            end
        end
        o_pending    = expected_symbols.size();
        o_fail_count = fail_total;
    end

endmodule

>>> dv/tb_golomb_rice_signed_decoder.sv
`timescale 1ns / 100ps
// Testbench top for the signed Golomb-Rice decoder: clock, reset, requests and verdict.
// Depends on grsd_pkg, grsd_tb_pkg and grsd_symbol_checker, which does all checking.
module tb_golomb_rice_signed_decoder;
    import grsd_pkg::*;
    import grsd_tb_pkg::*;

    localparam int PREFIX_LIMIT   = 12;
    localparam int POSITION_BITS  = 48;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int BATCH_ITEMS    = 110;
    localparam int QUIET_TAIL     = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [RAW_W-1:0]           i_cfg_wr_data;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic                       i_kind;
    logic [RICE_K_W-1:0]        i_rice_k;
    logic                       i_stream_bit;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [VALUE_W-1:0]  o_value;
    logic [STATUS_W-1:0]        o_status;
    logic [ERR_BYTE_W-1:0]      o_error_byte;
    int                         fail_count;
    int                         pending;

    logic                       idle_on = 1'b1;
    int                         hold_trigger = 0;
    int                         items_sent = 0;
    int                         ignored_sent = 0;
    logic [RAW_W-1:0]           cur_width = RAW_WIDTH_RESET;
    int                         open_zeros = -1;
    int                         idle_cycles;

    golomb_rice_signed_decoder #(
        .PREFIX_LIMIT  (PREFIX_LIMIT),
        .POSITION_BITS (POSITION_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_rice_k      (i_rice_k),
        .i_stream_bit  (i_stream_bit),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_status      (o_status),
        .o_error_byte  (o_error_byte)
    );

    grsd_symbol_checker #(
        .PREFIX_LIMIT  (PREFIX_LIMIT),
        .POSITION_BITS (POSITION_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_rice_k      (i_rice_k),
        .i_stream_bit  (i_stream_bit),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_value       (o_value),
        .i_status      (o_status),
        .i_error_byte  (o_error_byte),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[golomb_rice_signed_decoder] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int   hold_left;
        int   stall_left;
        int   hold_seen;
        logic next_ready;
        hold_left   = 0;
        stall_left  = 0;
        hold_seen   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_trigger) begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            i_out_ready = next_ready;
        end
    end

    task automatic send_item(input logic kind, input logic [RICE_K_W-1:0] k, input logic b);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_kind       = kind;
        i_rice_k     = k;
        i_stream_bit = b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_start(input logic [RICE_K_W-1:0] k);
        send_item(KIND_START, k, 1'($urandom));
    endtask

    task automatic send_bit(input logic b);
        send_item(KIND_BIT, RICE_K_W'($urandom), b);
    endtask

    task automatic send_zeros(input int n);
        repeat (n) send_bit(1'b0);
    endtask

    task automatic send_code_bits(input logic [31:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            send_bit(bits[i]);
        end
    endtask

    task automatic drain_and_settle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [RAW_W-1:0] w);
        drain_and_settle();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = w;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        cur_width     = w;
    endtask

    function automatic logic [31:0] escape_payload();
        logic [31:0] mask;
        mask = (32'd1 << cur_width) - 32'd1;
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return mask;
            2:       return 32'($urandom_range(0, 15)) & mask;
            default: return $urandom & mask;
        endcase
    endfunction

    task automatic send_random_symbol();
        int               shape;
        int               n;
        logic [RICE_K_W-1:0] k;
        logic             width_ok;
        width_ok = cur_width != '0 && cur_width <= RAW_WIDTH_MAX;
        shape    = $urandom_range(0, 99);
        if (shape < 8) begin
            send_start(RICE_K_W'($urandom_range(32, 255)));
        end else if (shape < 14) begin
            n = $urandom_range(1, 3);
            repeat (n) send_bit(1'($urandom));
            ignored_sent += n;
        end else if (shape < 22) begin
            send_start(RICE_K_W'($urandom_range(0, 31)));
            n = $urandom_range(0, 6);
            repeat (n) send_bit(1'($urandom));
        end else if (shape < 34) begin
            k = ($urandom_range(0, 5) == 0) ? RICE_K_W'($urandom_range(0, 31))
                                             : RICE_K_W'($urandom_range(0, 3));
            send_start(k);
            if (width_ok) begin
                send_zeros(PREFIX_LIMIT);
                send_code_bits(escape_payload(), cur_width);
            end
        end else if (shape < 40) begin
            send_start(RICE_K_W'(31));
            if (width_ok) begin
                send_zeros($urandom_range(2, PREFIX_LIMIT - 1));
                send_bit(1'b1);
                send_code_bits($urandom, 31);
            end
        end else begin
            k = ($urandom_range(0, 7) == 0) ? RICE_K_W'($urandom_range(0, 31))
                                             : RICE_K_W'($urandom_range(0, 6));
            send_start(k);
            if (width_ok) begin
                send_zeros($urandom_range(0, PREFIX_LIMIT - 1));
                send_bit(1'b1);
                send_code_bits($urandom, k);
            end
        end
    endtask

    initial begin
        int          random_target;
        int          batch_end;
        int          phase_idx;
        logic [RAW_W-1:0] next_width;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_START;
        i_rice_k      = '0;
        i_stream_bit  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Short directed cases at the reset raw width.
        send_bit(1'b1);
        send_start(RICE_K_W'(0));
        send_bit(1'b1);
        send_start(RICE_K_W'(255));
        send_start(K_LIMIT);
        send_start(RICE_K_W'(1));
        send_start(RICE_K_W'(0));
        send_bit(1'b0);
        send_bit(1'b1);

        // A canonical-looking escape of width one is non-canonical.
        write_width(RAW_W'(1));
        send_start(RICE_K_W'(0));
        send_zeros(PREFIX_LIMIT);
        send_bit(1'b0);

        // The raw width goes invalid while a prefix is open.
        send_start(RICE_K_W'(0));
        send_zeros(5);
        write_width(RAW_W'(0));
        send_zeros(PREFIX_LIMIT - 5);

        random_target = items_sent - ignored_sent + RANDOM_ITEMS;
        phase_idx     = 0;
        while (items_sent - ignored_sent < random_target) begin
            case (phase_idx % 8)
                0:       next_width = RAW_W'(31);
                1:       next_width = RAW_W'(1);
                2:       next_width = RAW_W'($urandom_range(2, 30));
                3:       next_width = RAW_W'(255);
                4:       next_width = RAW_W'(8);
                5:       next_width = RAW_W'($urandom_range(32, 254));
                6:       next_width = RAW_W'(0);
                default: next_width = RAW_W'($urandom_range(1, 31));
            endcase
            write_width(next_width);
            if (open_zeros >= 0) begin
                send_zeros(PREFIX_LIMIT - open_zeros);
                if (cur_width != '0 && cur_width <= RAW_WIDTH_MAX) begin
                    send_code_bits(escape_payload(), cur_width);
                end
                open_zeros = -1;
            end
            if (phase_idx == 4) begin
                hold_trigger++;
            end
            batch_end = items_sent - ignored_sent + BATCH_ITEMS;
            while (items_sent - ignored_sent < batch_end &&
                   items_sent - ignored_sent < random_target) begin
                if (random_target - (items_sent - ignored_sent) < QUIET_TAIL) begin
                    idle_on = 1'b0;
                end
                send_random_symbol();
            end
            if (cur_width != '0 && cur_width <= RAW_WIDTH_MAX && $urandom_range(0, 1) == 1) begin
                send_start(RICE_K_W'($urandom_range(0, 4)));
                open_zeros = $urandom_range(0, PREFIX_LIMIT - 1);
                send_zeros(open_zeros);
            end
            phase_idx++;
        end

        drain_and_settle();
        if (fail_count == 0 && pending == 0) begin
            $display("[golomb_rice_signed_decoder] OK");
        end else begin
            $display("[golomb_rice_signed_decoder] ERROR");
        end
        $finish;
    end

endmodule
